// ===== design/assert_macros.svh =====
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// checked on every edge, reset included
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== design/hbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

	localparam int MAX_MAP_WIDTH  = 256;
	localparam int MAX_MAP_HEIGHT = 256;

	localparam int COL_W   = $clog2(MAX_MAP_WIDTH);
	localparam int ROW_W   = $clog2(MAX_MAP_HEIGHT);
	localparam int ADDR_W  = $clog2(MAX_MAP_WIDTH * MAX_MAP_HEIGHT);
	localparam int DEPTH   = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;

	localparam int LEVEL_W = 8;
	localparam int DIM_W   = 9;
	localparam int CFG_W   = 24;
	localparam int POS_W   = 24;

	// shared multiplier: signed operands, full product
	localparam int MUL_W   = 25;
	localparam int PROD_W  = 2 * MUL_W;

	localparam logic [1:0] FUNC_LOAD     = 2'd0;
	localparam logic [1:0] FUNC_NEAREST  = 2'd1;
	localparam logic [1:0] FUNC_BILINEAR = 2'd2;

	localparam logic [2:0] CFG_MAP_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_MAP_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_SCALE_X     = 3'd2;
	localparam logic [2:0] CFG_SCALE_Z     = 3'd3;
	localparam logic [2:0] CFG_HEIGHT_GAIN = 3'd4;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [ADDR_W-1:0]  addr;
		logic [LEVEL_W-1:0] wdata;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== design/hbs_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single-port texel memory, registered read.
module hbs_store (
	input  wire                           clk,
	input  wire hbs_pkg::mem_req_t        req,
	output logic [hbs_pkg::LEVEL_W-1:0]   rd_data_q
);
	import hbs_pkg::*;

	logic [LEVEL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem_q[req.addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/hbs_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier, product registered; holds when en is low.
module hbs_mul (
	input  wire                                 clk,
	input  wire                                 en,
	input  wire signed [hbs_pkg::MUL_W-1:0]     a,
	input  wire signed [hbs_pkg::MUL_W-1:0]     b,
	output logic signed [hbs_pkg::PROD_W-1:0]   prod_q
);
	import hbs_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

`default_nettype wire

// ===== design/heightmap_bilinear_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel  Handshake             Payload
// cfg      cfg_we                cfg_index, cfg_data
// in       in_valid / in_ready   func, texel_column, texel_row, texel_level, pos_x, pos_z
// out      out_valid / out_ready height, outside_map
//
// Load: no result; func 3 is dropped. A query is paced by the one 25x25
// multiplier (up to six products in turn) and one texel read per cycle; a
// bilinear query off the map skips the texel reads.
// in_ready is high only while idle; a result waits in the output register and the
// next item may be accepted before it is taken. An untaken result stalls the next.
// arst_n resets control and config registers; the heightmap is not cleared.
module heightmap_bilinear_sampler (
	input  wire                             clk,
	input  wire                             arst_n,

	input  wire                             cfg_we,
	input  wire [2:0]                       cfg_index,
	input  wire [hbs_pkg::CFG_W-1:0]        cfg_data,

	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire [1:0]                       func,
	input  wire [7:0]                       texel_column,
	input  wire [7:0]                       texel_row,
	input  wire [7:0]                       texel_level,
	input  wire signed [hbs_pkg::POS_W-1:0] pos_x,
	input  wire signed [hbs_pkg::POS_W-1:0] pos_z,

	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [23:0]                     height,
	output logic                            outside_map
);
	import hbs_pkg::*;

	localparam int FX_W   = 16;                 // fraction kept after scaling
	localparam int FX_LSB = 8;                  // fraction bits dropped
	localparam int INT_LSB = FX_LSB + FX_W;     // binary point of the product
	localparam int TOP_W  = LEVEL_W + FX_W;     // Q8.16 level
	localparam int FIN_W  = TOP_W + FX_W + 2;   // Q8.32 blend with sign headroom
	localparam int HGT_W  = 24;

	typedef enum logic [3:0] {
		S_IDLE, S_MX, S_MZ, S_CHK, S_SEL, S_R00, S_R10, S_R01, S_R11,
		S_BOT, S_BLEND, S_FIN, S_NW, S_GAIN, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [DIM_W-1:0] map_width_q, map_height_q;
	logic [CFG_W-1:0] scale_x_q, scale_z_q, height_gain_q;
	logic [DIM_W-1:0] width_use, height_use, width_m1, height_m1;

	// datapath
	logic signed [POS_W-1:0] pos_x_q, pos_z_q;
	logic                    bilinear_q;
	logic signed [POS_W-1:0] x0_q, z0_q;
	logic [FX_W-1:0]         fx_q, fz_q;
	logic [COL_W-1:0]        xc_q, xc_next;
	logic [ROW_W-1:0]        zc_q, zc_next;
	logic [LEVEL_W-1:0]      h00_q, h10_q, h01_q;
	logic [TOP_W-1:0]        top_q, top_sum, bot_sum;
	logic [HGT_W-1:0]        res_height_q;
	logic                    res_flag_q;

	logic                    off_map;
	logic signed [LEVEL_W:0] diff_top, diff_bot;
	logic signed [MUL_W-1:0] diff_blend;
	logic signed [FIN_W-1:0] fin;
	logic [TOP_W-1:0]        fin_level;

	logic                    in_accept, do_load, query_accept;
	mem_req_t                mem_req;
	logic [LEVEL_W-1:0]      rd_data_q;
	logic [COL_W-1:0]        rd_col;
	logic [ROW_W-1:0]        rd_row;

	logic                     mul_en;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;

	logic               out_valid_q, outside_map_q;
	logic [HGT_W-1:0]   height_q;

	function automatic logic [ADDR_W-1:0] texel_addr(input logic [COL_W-1:0] c,
		input logic [ROW_W-1:0] r);
		texel_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_MAP_WIDTH) + ADDR_W'(c));
	endfunction

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= DIM_W'(256);
			map_height_q  <= DIM_W'(256);
			scale_x_q     <= CFG_W'(65536);
			scale_z_q     <= CFG_W'(65536);
			height_gain_q <= CFG_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_WIDTH:   map_width_q   <= cfg_data[DIM_W-1:0];
				CFG_MAP_HEIGHT:  map_height_q  <= cfg_data[DIM_W-1:0];
				CFG_SCALE_X:     scale_x_q     <= cfg_data;
				CFG_SCALE_Z:     scale_z_q     <= cfg_data;
				CFG_HEIGHT_GAIN: height_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize saturates to the store size
	always_comb begin
		if (map_width_q == '0) begin
			width_use = DIM_W'(1);
		end else if (32'(map_width_q) > MAX_MAP_WIDTH) begin
			width_use = DIM_W'(MAX_MAP_WIDTH);
		end else begin
			width_use = map_width_q;
		end
		if (map_height_q == '0) begin
			height_use = DIM_W'(1);
		end else if (32'(map_height_q) > MAX_MAP_HEIGHT) begin
			height_use = DIM_W'(MAX_MAP_HEIGHT);
		end else begin
			height_use = map_height_q;
		end
		width_m1  = width_use - DIM_W'(1);
		height_m1 = height_use - DIM_W'(1);
	end

	// ---------------------------------------------------------------- input side
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign do_load   = in_accept && (func == FUNC_LOAD)
		&& (32'(texel_column) < MAX_MAP_WIDTH) && (32'(texel_row) < MAX_MAP_HEIGHT);
	assign query_accept = in_accept && (func inside {FUNC_NEAREST, FUNC_BILINEAR});

	// ---------------------------------------------------------------- neighbour selection
	// bilinear needs x0, x0+1, z0 and z0+1 inside the map (x0 and z0 are floors, may be negative)
	always_comb begin
		off_map = x0_q[POS_W-1] || z0_q[POS_W-1]
			|| ({1'b0, $unsigned(x0_q)} + 25'd1 >= 25'(width_use))
			|| ({1'b0, $unsigned(z0_q)} + 25'd1 >= 25'(height_use));

		if (bilinear_q) begin
			xc_next = x0_q[COL_W-1:0];
			zc_next = z0_q[ROW_W-1:0];
		end else begin
			if (x0_q[POS_W-1]) begin
				xc_next = '0;
			end else if ($unsigned(x0_q) >= POS_W'(width_use)) begin
				xc_next = width_m1[COL_W-1:0];
			end else begin
				xc_next = x0_q[COL_W-1:0];
			end
			if (z0_q[POS_W-1]) begin
				zc_next = '0;
			end else if ($unsigned(z0_q) >= POS_W'(height_use)) begin
				zc_next = height_m1[ROW_W-1:0];
			end else begin
				zc_next = z0_q[ROW_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- memory port
	always_comb begin
		rd_col = xc_q;
		rd_row = zc_q;
		case (state_q)
			S_R10: rd_col = xc_q + COL_W'(1);
			S_R01: rd_row = zc_q + ROW_W'(1);
			S_R11: begin
				rd_col = xc_q + COL_W'(1);
				rd_row = zc_q + ROW_W'(1);
			end
			default: ;
		endcase

		mem_req.we    = do_load;
		mem_req.re    = (state_q inside {S_R00, S_R10, S_R01, S_R11});
		mem_req.wdata = texel_level;
		if (do_load) begin
			mem_req.addr = texel_addr(COL_W'(texel_column), ROW_W'(texel_row));
		end else begin
			mem_req.addr = texel_addr(rd_col, rd_row);
		end
	end

	hbs_store u_store (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (rd_data_q)
	);

	// ---------------------------------------------------------------- blend arithmetic
	always_comb begin
		diff_top   = $signed({1'b0, h10_q}) - $signed({1'b0, h00_q});
		diff_bot   = $signed({1'b0, rd_data_q}) - $signed({1'b0, h01_q});
		// exact partial sums are known to fit TOP_W, so wrap-around add is safe
		top_sum    = {h00_q, {FX_W{1'b0}}} + prod_q[TOP_W-1:0];
		bot_sum    = {h01_q, {FX_W{1'b0}}} + prod_q[TOP_W-1:0];
		diff_blend = $signed({1'b0, bot_sum}) - $signed({1'b0, top_q});
		fin        = $signed({2'b00, top_q, {FX_W{1'b0}}}) + $signed(prod_q[FIN_W-1:0]);
		fin_level  = fin[FIN_W-1] ? '0 : fin[TOP_W+FX_W-1:FX_W];
	end

	// ---------------------------------------------------------------- shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_MX: begin
				mul_a = MUL_W'(pos_x_q);
				mul_b = $signed({1'b0, scale_x_q});
			end
			S_MZ: begin
				mul_a = MUL_W'(pos_z_q);
				mul_b = $signed({1'b0, scale_z_q});
			end
			S_R11: begin
				mul_a = $signed(MUL_W'(fx_q));
				mul_b = MUL_W'(diff_top);
			end
			S_BOT: begin
				mul_a = $signed(MUL_W'(fx_q));
				mul_b = MUL_W'(diff_bot);
			end
			S_BLEND: begin
				mul_a = $signed(MUL_W'(fz_q));
				mul_b = diff_blend;
			end
			S_FIN: begin
				mul_a = $signed({1'b0, fin_level});
				mul_b = $signed({1'b0, height_gain_q});
			end
			S_NW: begin
				mul_a = $signed({1'b0, rd_data_q, {FX_W{1'b0}}});
				mul_b = $signed({1'b0, height_gain_q});
			end
			default: mul_en = 1'b0;
		endcase
	end

	hbs_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// ---------------------------------------------------------------- datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pos_x_q    <= pos_x;
			pos_z_q    <= pos_z;
			bilinear_q <= (func == FUNC_BILINEAR);
		end
		case (state_q)
			S_MZ: begin
				x0_q <= prod_q[INT_LSB+POS_W-1:INT_LSB];
				fx_q <= prod_q[INT_LSB-1:FX_LSB];
			end
			S_CHK: begin
				z0_q <= prod_q[INT_LSB+POS_W-1:INT_LSB];
				fz_q <= prod_q[INT_LSB-1:FX_LSB];
			end
			S_SEL: begin
				xc_q         <= xc_next;
				zc_q         <= zc_next;
				res_height_q <= '0;
				res_flag_q   <= 1'b1;
			end
			S_R10: h00_q <= rd_data_q;
			S_R01: h10_q <= rd_data_q;
			S_R11: h01_q <= rd_data_q;
			S_BOT: top_q <= top_sum;
			// Q8.16 level times Q8.16 gain is below 2^48: the top never saturates
			S_GAIN: begin
				res_height_q <= prod_q[INT_LSB+HGT_W-1:INT_LSB];
				res_flag_q   <= 1'b0;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			height_q      <= '0;
			outside_map_q <= 1'b0;
		end else begin
			// the done step reloads the output register on its own
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (query_accept) begin
						state_q <= S_MX;
					end
				end
				S_MX:  state_q <= S_MZ;
				S_MZ:  state_q <= S_CHK;
				S_CHK: state_q <= S_SEL;
				S_SEL: begin
					if (bilinear_q && off_map) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_R00;
					end
				end
				S_R00:   state_q <= bilinear_q ? S_R10 : S_NW;
				S_R10:   state_q <= S_R01;
				S_R01:   state_q <= S_R11;
				S_R11:   state_q <= S_BOT;
				S_BOT:   state_q <= S_BLEND;
				S_BLEND: state_q <= S_FIN;
				S_FIN:   state_q <= S_GAIN;
				S_NW:    state_q <= S_GAIN;
				S_GAIN:  state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						height_q      <= res_height_q;
						outside_map_q <= res_flag_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign height      = height_q;
	assign outside_map = outside_map_q;

	// ---------------------------------------------------------------- checks
	`ASSERT_PROP(a_query_holds_input, query_accept |=> !in_ready, "query accepted, still ready")
	`ASSERT_PROP(a_off_map_zero, (out_valid && outside_map) |-> (height == '0), "off-map height")
	`ASSERT_PROP(a_write_when_idle, mem_req.we |-> (state_q == S_IDLE && !mem_req.re), "busy write")
	`ASSERT_PROP(a_result_from_done, $rose(out_valid) |-> $past(state_q == S_DONE), "early result")
	`ASSERT_RST(a_reset_quiet, !arst_n |-> (!out_valid && in_ready), "busy in reset")

endmodule

`default_nettype wire

// ===== dv/heightmap_bilinear_sampler_tb.sv =====
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_tb;
	import hbs_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0]  fn;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  level;
		logic [23:0] px;
		logic [23:0] pz;
	} sampler_req_t;

	typedef struct packed {
		logic [23:0] height;
		logic        outside_map;
	} height_sample_t;

	typedef struct packed {
		sampler_req_t   req;
		logic           typed;
		height_sample_t want;
	} directed_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b1;
	logic                    cfg_we = 1'b0;
	logic [2:0]              cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	wire                     in_ready;
	logic [1:0]              func = '0;
	logic [7:0]              texel_column = '0;
	logic [7:0]              texel_row = '0;
	logic [7:0]              texel_level = '0;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_z = '0;
	wire                     out_valid;
	logic                    out_ready = 1'b0;
	wire [23:0]              height;
	wire                     outside_map;

	heightmap_bilinear_sampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.texel_column (texel_column),
		.texel_row    (texel_row),
		.texel_level  (texel_level),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.height       (height),
		.outside_map  (outside_map)
	);

	// shadow of the heightmap and of the register file
	logic [7:0]  level_mem [0:DEPTH-1];
	bit          texel_loaded [0:DEPTH-1];
	logic [8:0]  cur_width = 9'd256;
	logic [8:0]  cur_height = 9'd256;
	logic [23:0] cur_scale_x = 24'h010000;
	logic [23:0] cur_scale_z = 24'h010000;
	logic [23:0] cur_gain = 24'h010000;

	height_sample_t pending_samples[$];
	height_sample_t head_sample;
	directed_row_t  directed_rows[$];
	int             tap_addr[4];
	bit             steady = 1'b0;
	int             mismatches = 0;
	int             cycle_count = 0;
	int             stall_left = 0;

	always #5 clk = ~clk;

	function automatic int dim_in_use(logic [8:0] v, int max_dim);
		if (v == 0)
			return 1;
		if (int'(v) > max_dim)
			return max_dim;
		return int'(v);
	endfunction

	// position (Q16.8) times scale (Q8.16): pixel coordinate with 24 fraction bits
	function automatic longint pixel_product(logic [23:0] pos, logic [23:0] scale);
		return longint'($signed(pos)) * longint'(scale);
	endfunction

	function automatic logic [23:0] apply_gain(longint level_q16);
		longint scaled;
		scaled = (level_q16 * longint'(cur_gain)) >>> 24;
		if (scaled > 64'hFFFFFF)
			return 24'hFFFFFF;
		return scaled[23:0];
	endfunction

	// texels a query reads, left in tap_addr; zero for off-map bilinear and non-queries
	function automatic int query_taps(sampler_req_t r);
		longint xp, zp, x0, z0;
		int w, h, base;
		w = dim_in_use(cur_width, MAX_MAP_WIDTH);
		h = dim_in_use(cur_height, MAX_MAP_HEIGHT);
		xp = pixel_product(r.px, cur_scale_x);
		zp = pixel_product(r.pz, cur_scale_z);
		x0 = xp >>> 24;
		z0 = zp >>> 24;
		if (r.fn == FUNC_NEAREST) begin
			if (x0 < 0) x0 = 0;
			if (x0 >= w) x0 = longint'(w - 1);
			if (z0 < 0) z0 = 0;
			if (z0 >= h) z0 = longint'(h - 1);
			tap_addr[0] = int'(z0) * MAX_MAP_WIDTH + int'(x0);
			return 1;
		end
		if (r.fn != FUNC_BILINEAR)
			return 0;
		if (x0 < 0 || z0 < 0 || x0 + 1 >= w || z0 + 1 >= h)
			return 0;
		base = int'(z0) * MAX_MAP_WIDTH + int'(x0);
		tap_addr[0] = base;
		tap_addr[1] = base + 1;
		tap_addr[2] = base + MAX_MAP_WIDTH;
		tap_addr[3] = base + MAX_MAP_WIDTH + 1;
		return 4;
	endfunction

	function automatic height_sample_t predict_sample(sampler_req_t r);
		height_sample_t s;
		longint xp, zp, fx, fz, h00, h10, h01, h11, top, bot, blend;
		int n;
		s = '0;
		n = query_taps(r);
		if (r.fn == FUNC_NEAREST) begin
			s.height = apply_gain(longint'(level_mem[tap_addr[0]]) <<< 16);
			return s;
		end
		if (n == 0) begin
			s.outside_map = 1'b1;
			return s;
		end
		xp = pixel_product(r.px, cur_scale_x);
		zp = pixel_product(r.pz, cur_scale_z);
		// 16 fraction bits below the point, the lowest 8 dropped
		fx = (xp >>> 8) & 64'hFFFF;
		fz = (zp >>> 8) & 64'hFFFF;
		h00 = longint'(level_mem[tap_addr[0]]);
		h10 = longint'(level_mem[tap_addr[1]]);
		h01 = longint'(level_mem[tap_addr[2]]);
		h11 = longint'(level_mem[tap_addr[3]]);
		top = (h00 <<< 16) + fx * (h10 - h00);
		bot = (h01 <<< 16) + fx * (h11 - h01);
		blend = (top <<< 16) + fz * (bot - top);
		if (blend < 0)
			blend = 0;
		s.height = apply_gain(blend >>> 16);
		return s;
	endfunction

	// mostly short, sometimes long
	function automatic int idle_length();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// world position aimed at pixel -1 .. dim+1 so most queries land on or near the map
	function automatic logic [23:0] aim_pos(logic [23:0] scale, int dim);
		longint target, pos;
		if (scale == 0 || $urandom_range(0, 9) < 3)
			return 24'($urandom);
		target = ((longint'($urandom_range(0, dim + 2)) - 1) <<< 24)
			+ longint'($urandom_range(0, 24'hFFFFFF));
		pos = target / longint'(scale);
		if (pos > 64'sd8388607)
			pos = 64'sd8388607;
		if (pos < -64'sd8388608)
			pos = -64'sd8388608;
		return pos[23:0];
	endfunction

	task automatic table_row(input logic [1:0] fn, input logic [7:0] col, row, level,
			input logic [23:0] px, pz, input logic typed, input logic [23:0] h,
			input logic o);
		directed_row_t d;
		d.req = '{fn: fn, col: col, row: row, level: level, px: px, pz: pz};
		d.typed = typed;
		d.want = '{height: h, outside_map: o};
		directed_rows.push_back(d);
	endtask

	// called at a rising edge; returns at the edge that accepts the transaction
	task automatic send_item(input sampler_req_t r, input logic typed,
			input height_sample_t want);
		int gap;
		int addr;
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= r.fn;
		texel_column <= r.col;
		texel_row <= r.row;
		texel_level <= r.level;
		pos_x <= r.px;
		pos_z <= r.pz;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		case (r.fn)
			FUNC_LOAD: begin
				addr = int'(r.row) * MAX_MAP_WIDTH + int'(r.col);
				level_mem[addr] = r.level;
				texel_loaded[addr] = 1'b1;
			end
			FUNC_NEAREST, FUNC_BILINEAR:
				pending_samples.push_back(typed ? want : predict_sample(r));
			default: ;
		endcase
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_MAP_WIDTH:   cur_width = data[8:0];
			CFG_MAP_HEIGHT:  cur_height = data[8:0];
			CFG_SCALE_X:     cur_scale_x = data;
			CFG_SCALE_Z:     cur_scale_z = data;
			CFG_HEIGHT_GAIN: cur_gain = data;
			default: ;
		endcase
	endtask

	task automatic write_config(input int w, h, input logic [23:0] sx, sz, g);
		write_reg(CFG_MAP_WIDTH, CFG_W'(w));
		write_reg(CFG_MAP_HEIGHT, CFG_W'(h));
		write_reg(CFG_SCALE_X, sx);
		write_reg(CFG_SCALE_Z, sz);
		write_reg(CFG_HEIGHT_GAIN, g);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int n);
		sampler_req_t r, fill;
		height_sample_t none;
		int issued, pick, taps;
		int taps_copy[4];
		issued = 0;
		none = '0;
		while (issued < n) begin
			r = '{fn: FUNC_LOAD, col: 8'($urandom), row: 8'($urandom),
				level: 8'($urandom), px: 24'($urandom), pz: 24'($urandom)};
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				r.fn = FUNC_UNUSED;
			end else if (pick >= 18) begin
				r.fn = (pick < 55) ? FUNC_NEAREST : FUNC_BILINEAR;
				r.px = aim_pos(cur_scale_x, dim_in_use(cur_width, MAX_MAP_WIDTH));
				r.pz = aim_pos(cur_scale_z, dim_in_use(cur_height, MAX_MAP_HEIGHT));
				// never let a query read a texel that has not been loaded
				taps = query_taps(r);
				taps_copy = tap_addr;
				for (int t = 0; t < taps; t++) begin
					if (!texel_loaded[taps_copy[t]]) begin
						fill = '{fn: FUNC_LOAD, col: 8'(taps_copy[t] % MAX_MAP_WIDTH),
							row: 8'(taps_copy[t] / MAX_MAP_WIDTH), level: 8'($urandom),
							px: 24'($urandom), pz: 24'($urandom)};
						send_item(fill, 1'b0, none);
						issued++;
					end
				end
			end
			send_item(r, 1'b0, none);
			if (r.fn != FUNC_UNUSED)
				issued++;
			if ($urandom_range(0, 39) == 0)
				drain_results();
		end
	endtask

	always @(posedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left = idle_length();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// outputs are stable at the falling edge; a transaction seen here completes at the next rise
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: height %h outside_map %b",
						height, outside_map);
			end else begin
				head_sample = pending_samples.pop_front();
				if (height !== head_sample.height
						|| outside_map !== head_sample.outside_map) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: height exp %h got %h, outside_map exp %b got %b",
							head_sample.height, height, head_sample.outside_map,
							outside_map);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		// falling edge at time zero starts the asynchronous reset
		arst_n <= 1'b0;
		// reset config: 256x256 map, unit scales, unit gain
		table_row(FUNC_LOAD, 8'd0, 8'd0, 8'd255, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_LOAD, 8'd1, 8'd0, 8'd0, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_LOAD, 8'd0, 8'd1, 8'd128, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_LOAD, 8'd1, 8'd1, 8'd64, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_LOAD, 8'd255, 8'd255, 8'd200, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_LOAD, 8'd254, 8'd255, 8'd1, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_LOAD, 8'd255, 8'd254, 8'd2, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_LOAD, 8'd254, 8'd254, 8'd3, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		// unused selector is dropped
		table_row(FUNC_UNUSED, 8'hAA, 8'h55, 8'hFF, 24'h7FFFFF, 24'h800000, 1'b0, 24'h0, 1'b0);
		// nearest: origin, clamped low, clamped high, clamped x only
		table_row(FUNC_NEAREST, 8'd0, 8'd0, 8'd0, 24'h000000, 24'h000000, 1'b1, 24'h00FF00, 1'b0);
		table_row(FUNC_NEAREST, 8'd0, 8'd0, 8'd0, 24'h800000, 24'h800000, 1'b1, 24'h00FF00, 1'b0);
		table_row(FUNC_NEAREST, 8'd0, 8'd0, 8'd0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 24'h00C800, 1'b0);
		table_row(FUNC_NEAREST, 8'd0, 8'd0, 8'd0, 24'hFFFF00, 24'h000100, 1'b1, 24'h008000, 1'b0);
		// bilinear: on a texel, half steps, just below zero, far edge, off the map
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h000000, 24'h000000, 1'b1, 24'h00FF00, 1'b0);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h000080, 24'h000000, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h000080, 24'h000080, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'hFFFFFF, 24'h000000, 1'b1, 24'h000000, 1'b1);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h000000, 24'hFFFFFF, 1'b1, 24'h000000, 1'b1);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h00FE00, 24'h00FE00, 1'b1, 24'h000300, 1'b0);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h00FEC0, 24'h00FE40, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h00FF00, 24'h000000, 1'b1, 24'h000000, 1'b1);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 24'h000000, 1'b1);
		// overwrite a texel with level zero
		table_row(FUNC_LOAD, 8'd0, 8'd0, 8'd0, 24'h0, 24'h0, 1'b0, 24'h0, 1'b0);
		table_row(FUNC_NEAREST, 8'd0, 8'd0, 8'd0, 24'h00007F, 24'h00007F, 1'b1, 24'h000000, 1'b0);
		table_row(FUNC_BILINEAR, 8'd0, 8'd0, 8'd0, 24'h0000FF, 24'h0000FF, 1'b0, 24'h0, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		run_random(40);

		drain_results();
		write_config(8, 8, 24'h010000, 24'h010000, 24'h010000);
		run_random(60);

		// 2x2 map, quarter scale along x, largest gain
		drain_results();
		write_config(2, 2, 24'h004000, 24'h010000, 24'hFFFFFF);
		run_random(40);

		// zero width acts as one, oversized height saturates; zero x scale and zero gain
		drain_results();
		write_config(0, 511, 24'h000000, 24'hFFFFFF, 24'h000000);
		run_random(30);

		drain_results();
		write_config(256, 256, 24'h002000, 24'h002000, 24'h008000);
		run_random(40);

		drain_results();
		steady = 1'b1;
		write_config(16, 5, 24'h030000, 24'h018000, 24'h018000);
		run_random(50);

		drain_results();
		steady = 1'b0;
		write_config(3, 256, 24'h000100, 24'h800000, 24'h000001);
		run_random(40);

		drain_results();
		write_config(300, 2, 24'h010000, 24'h008000, 24'h000001);
		run_random(30);

		for (int k = 0; k < 3; k++) begin
			drain_results();
			write_config(($urandom_range(0, 1) != 0) ? $urandom_range(2, 12) : $urandom_range(0, 511),
				($urandom_range(0, 1) != 0) ? $urandom_range(2, 12) : $urandom_range(0, 511),
				24'($urandom), 24'($urandom), 24'($urandom));
			run_random(40);
		end

		drain_results();
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
